[rtl/sitm_pkg.sv]
// Shared types, constants and codes for the sorted interval table block.
// Used by sitm_cmp and the top level under rtl/; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package sitm_pkg;

	// Table geometry
	localparam int TABLE_DEPTH = 1024;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int COUNT_FIELD_W = 11;
	localparam int COORD_W = 32;

	// Operation codes
	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_MERGE  = 2'd1,
		OP_READ   = 2'd2
	} op_e;

	// Status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_e;

	// Sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_RD_WAIT,
		S_ISCAN,
		S_DUP,
		S_SHIFT,
		S_PUT,
		S_M_RD,
		S_M_C1,
		S_M_C2,
		S_M_FIN
	} state_e;

	typedef struct packed {
		logic [1:0]                op;
		logic signed [COORD_W-1:0] span_start;
		logic signed [COORD_W-1:0] span_end;
		logic [9:0]                entry_index;
	} req_t;

	typedef struct packed {
		logic [1:0]                status;
		logic [COUNT_FIELD_W-1:0]  entry_count;
		logic signed [COORD_W-1:0] read_start;
		logic signed [COORD_W-1:0] read_end;
	} rsp_t;

	// One stored interval
	typedef struct packed {
		logic signed [COORD_W-1:0] span_start;
		logic signed [COORD_W-1:0] span_end;
	} entry_t;

	// Flags from the shared comparator
	typedef struct packed {
		logic lt;
		logic eq;
	} cmp_t;

endpackage

`default_nettype wire

[rtl/sitm_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Holds the interval table; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module sitm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[rtl/sitm_cmp.sv]
// Shared signed 32-bit comparator used by the scan, duplicate update and merge steps.
// Depends on sitm_pkg for the flag struct.
`timescale 1ns / 1ps
`default_nettype none

module sitm_cmp (
	input  wire logic signed [31:0] lhs,
	input  wire logic signed [31:0] rhs,
	output sitm_pkg::cmp_t          flags
);
	import sitm_pkg::*;

	// Two's complement ordering and equality of the selected operands.
	always_comb begin
		flags.lt = (lhs < rhs);
		flags.eq = (lhs == rhs);
	end

endmodule

`default_nettype wire

[rtl/sorted_interval_table_merge_top.sv]
// Top level of the sorted interval table: sequencer, table RAM and shared comparator.
// Depends on sitm_pkg, sitm_ram and sitm_cmp.
//
// Usage: drive a request on request and raise start; the request is taken at a
// clock edge where start is high and busy is low. busy stays high while the
// sequencer works. The response appears on result, marked by done, which is high for
// exactly one cycle; the receiver cannot hold it off, and busy is already low in that cycle.
// Steps from the accepting edge to the done cycle:
//   full insert, read beyond count, merge of an empty table, unused op: answered
//     straight from idle
//   read: one RAM read
//   insert of a new start at sorted place p with n entries held: a position scan
//     with one RAM read per entry, then a shift with one RAM read per entry moved
//     up (none when p = n), one entry per cycle through the single read port, then
//     the write of the new entry
//   insert whose start is already held at place p: a scan up to p, then the end update
//   merge: per entry a read, a start compare and, on overlap, an end compare
// One request is in flight at a time; the next may be started in the done cycle.
// Reset clears the entry count and the sequencer; the table contents are not
// cleared and need no clearing pass, since only entries below the count are read.
`timescale 1ns / 1ps
`default_nettype none

module sorted_interval_table_merge_top (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire sitm_pkg::req_t request,
	output logic                busy,
	output logic                done,
	output sitm_pkg::rsp_t      result
);
	import sitm_pkg::*;

	state_e                state_q, state_d;
	req_t                  req_q, req_d;
	logic [IDX_W-1:0]      addr_q, addr_d;
	logic [IDX_W-1:0]      chk_q, chk_d;
	logic [IDX_W-1:0]      pos_q, pos_d;
	logic [CNT_W-1:0]      rem_q, rem_d;
	logic                  pend_q, pend_d;
	logic [COORD_W-1:0]    dup_end_q, dup_end_d;
	logic [COORD_W-1:0]    cur_end_q, cur_end_d;
	entry_t                kept_q, kept_d;
	logic [IDX_W-1:0]      kept_idx_q, kept_idx_d;
	logic [CNT_W-1:0]      cnt_q, cnt_d;
	rsp_t                  res_q, res_d;
	logic                  done_q, done_d;

	logic                  ram_we;
	logic [IDX_W-1:0]      ram_waddr;
	entry_t                ram_wdata;
	logic [IDX_W-1:0]      ram_raddr;
	entry_t                ram_rdata;

	logic signed [31:0]    cmp_lhs;
	logic signed [31:0]    cmp_rhs;
	cmp_t                  cmp_flags;
	logic                  last_entry;

	// Table storage.
	sitm_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// The one comparator shared by the scan, the duplicate update and the merge.
	sitm_cmp u_cmp (
		.lhs  (cmp_lhs),
		.rhs  (cmp_rhs),
		.flags(cmp_flags)
	);

	// True when the merge walk has reached the last held entry.
	assign last_entry = ((CNT_W'(addr_q) + CNT_W'(1)) == cnt_q);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			done_q  <= done_d;
			pend_q  <= pend_d;
		end
	end

	// Datapath registers, no reset needed.
	always_ff @(posedge clk) begin
		req_q      <= req_d;
		addr_q     <= addr_d;
		chk_q      <= chk_d;
		pos_q      <= pos_d;
		rem_q      <= rem_d;
		dup_end_q  <= dup_end_d;
		cur_end_q  <= cur_end_d;
		kept_q     <= kept_d;
		kept_idx_q <= kept_idx_d;
		res_q      <= res_d;
	end

	// Next state, datapath updates, RAM and comparator control.
	always_comb begin
		state_d    = state_q;
		req_d      = req_q;
		addr_d     = addr_q;
		chk_d      = chk_q;
		pos_d      = pos_q;
		rem_d      = rem_q;
		pend_d     = pend_q;
		dup_end_d  = dup_end_q;
		cur_end_d  = cur_end_q;
		kept_d     = kept_q;
		kept_idx_d = kept_idx_q;
		cnt_d      = cnt_q;
		res_d      = res_q;
		done_d     = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = pos_q;
		ram_wdata  = ram_rdata;
		ram_raddr  = addr_q;
		cmp_lhs    = ram_rdata.span_start;
		cmp_rhs    = req_q.span_start;

		case (state_q)
			S_IDLE: begin
				if (start) begin
					req_d = request;
					res_d.status      = ST_OK;
					res_d.entry_count = COUNT_FIELD_W'(cnt_q);
					res_d.read_start  = '0;
					res_d.read_end    = '0;
					case (request.op)
						OP_INSERT: begin
							if (cnt_q == CNT_W'(TABLE_DEPTH)) begin
								res_d.status = ST_FULL;
								done_d = 1'b1;
							end else begin
								addr_d  = '0;
								pend_d  = 1'b0;
								state_d = S_ISCAN;
							end
						end
						OP_MERGE: begin
							if (cnt_q == '0) begin
								done_d = 1'b1;
							end else begin
								addr_d  = '0;
								state_d = S_M_RD;
							end
						end
						OP_READ: begin
							if (32'(request.entry_index) < 32'(cnt_q)) begin
								ram_raddr = IDX_W'(request.entry_index);
								state_d   = S_RD_WAIT;
							end else begin
								res_d.status = ST_RANGE;
								done_d = 1'b1;
							end
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end

			// Read data is back from the RAM.
			S_RD_WAIT: begin
				res_d.read_start = ram_rdata.span_start;
				res_d.read_end   = ram_rdata.span_end;
				done_d  = 1'b1;
				state_d = S_IDLE;
			end

			// Walk upward to the first entry whose start is not below the new start.
			S_ISCAN: begin
				if (pend_q && !cmp_flags.lt) begin
					pos_d  = chk_q;
					pend_d = 1'b0;
					if (cmp_flags.eq) begin
						dup_end_d = ram_rdata.span_end;
						state_d   = S_DUP;
					end else begin
						rem_d   = cnt_q - CNT_W'(chk_q);
						addr_d  = IDX_W'(cnt_q - CNT_W'(1));
						state_d = S_SHIFT;
					end
				end else if (CNT_W'(addr_q) < cnt_q) begin
					ram_raddr = addr_q;
					chk_d     = addr_q;
					pend_d    = 1'b1;
					addr_d    = addr_q + IDX_W'(1);
				end else begin
					pos_d   = IDX_W'(cnt_q);
					pend_d  = 1'b0;
					state_d = S_PUT;
				end
			end

			// Matching start: raise the stored end if the new one is larger.
			S_DUP: begin
				cmp_lhs = dup_end_q;
				cmp_rhs = req_q.span_end;
				if (cmp_flags.lt) begin
					ram_we    = 1'b1;
					ram_waddr = pos_q;
					ram_wdata = '{span_start: req_q.span_start, span_end: req_q.span_end};
				end
				done_d  = 1'b1;
				state_d = S_IDLE;
			end

			// Move entries up by one, from the top down to the insert place.
			S_SHIFT: begin
				if (pend_q) begin
					ram_we    = 1'b1;
					ram_waddr = chk_q;
					ram_wdata = ram_rdata;
				end
				if (rem_q != '0) begin
					ram_raddr = addr_q;
					chk_d     = addr_q + IDX_W'(1);
					pend_d    = 1'b1;
					addr_d    = addr_q - IDX_W'(1);
					rem_d     = rem_q - CNT_W'(1);
				end else begin
					pend_d  = 1'b0;
					state_d = S_PUT;
				end
			end

			// Write the new interval into its place.
			S_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q;
				ram_wdata = '{span_start: req_q.span_start, span_end: req_q.span_end};
				cnt_d     = cnt_q + CNT_W'(1);
				res_d.entry_count = COUNT_FIELD_W'(cnt_q + CNT_W'(1));
				done_d  = 1'b1;
				state_d = S_IDLE;
			end

			S_M_RD: begin
				ram_raddr = addr_q;
				state_d   = S_M_C1;
			end

			// Compare the kept end with the start of the entry just read.
			S_M_C1: begin
				cmp_lhs = kept_q.span_end;
				cmp_rhs = ram_rdata.span_start;
				if (addr_q == '0) begin
					kept_d     = ram_rdata;
					kept_idx_d = '0;
					addr_d     = addr_q + IDX_W'(1);
					state_d    = last_entry ? S_M_FIN : S_M_RD;
				end else if (cmp_flags.lt) begin
					ram_we     = 1'b1;
					ram_waddr  = kept_idx_q;
					ram_wdata  = kept_q;
					kept_idx_d = kept_idx_q + IDX_W'(1);
					kept_d     = ram_rdata;
					addr_d     = addr_q + IDX_W'(1);
					state_d    = last_entry ? S_M_FIN : S_M_RD;
				end else begin
					cur_end_d = ram_rdata.span_end;
					state_d   = S_M_C2;
				end
			end

			// Overlap: keep the larger end.
			S_M_C2: begin
				cmp_lhs = kept_q.span_end;
				cmp_rhs = cur_end_q;
				if (cmp_flags.lt) begin
					kept_d.span_end = cur_end_q;
				end
				addr_d  = addr_q + IDX_W'(1);
				state_d = last_entry ? S_M_FIN : S_M_RD;
			end

			// Flush the last kept interval and set the new count.
			S_M_FIN: begin
				ram_we    = 1'b1;
				ram_waddr = kept_idx_q;
				ram_wdata = kept_q;
				cnt_d     = CNT_W'(kept_idx_q) + CNT_W'(1);
				res_d.entry_count = COUNT_FIELD_W'(CNT_W'(kept_idx_q) + CNT_W'(1));
				done_d  = 1'b1;
				state_d = S_IDLE;
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;

`ifndef ASSERT_OFF
	// The count never passes the table depth.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count above table depth");

	// The count only changes together with a response.
	a_cnt_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != $past(cnt_q)) |-> done_q)
		else $error("entry count changed without a response");

	// Writes never land beyond the slot just above the held entries.
	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (CNT_W'(ram_waddr) <= cnt_q))
		else $error("table write beyond held entries");

	// A full status is only reported with a full table.
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && res_q.status == ST_FULL) |-> (cnt_q == CNT_W'(TABLE_DEPTH)))
		else $error("full status with room left");

	// The sequencer is back at rest whenever a response is shown.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy)
		else $error("response shown while busy");
`endif

endmodule

`default_nettype wire

[dv/sorted_interval_table_merge_top_tb.sv]
// Self-checking testbench for the sorted interval table: it drives insert, merge and read
// requests and checks every response against a table kept in step inside the bench.
// Depends on sitm_pkg and sorted_interval_table_merge_top.
`timescale 1ns / 1ps

module sorted_interval_table_merge_top_tb;
	import sitm_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [31:0] COORD_MIN = 32'h8000_0000;
	localparam logic [31:0] COORD_MAX = 32'h7fff_ffff;
	localparam logic [31:0] ONE = 32'h0001_0000;      // 1.0 in Q16.16
	localparam logic [31:0] BAND_W = 32'h0800_0000;   // coordinate band per episode
	localparam int BAND_LIMIT = 31;
	localparam int RANDOM_ITEMS = 480;
	localparam int LARGE_FILL = 64;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t request = '0;
	logic busy;
	logic done;
	rsp_t result;

	sorted_interval_table_merge_top DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.request (request),
		.busy    (busy),
		.done    (done),
		.result  (result)
	);

	always #4 clk = ~clk;

	// Expected table contents and the responses still owed by the block.
	logic signed [31:0] span_lo [TABLE_DEPTH];
	logic signed [31:0] span_hi [TABLE_DEPTH];
	int held = 0;
	rsp_t pending_rsp [$];

	int fail_count = 0;
	int rsp_seen = 0;
	int n_insert = 0;
	int n_full = 0;
	int n_merge = 0;
	int n_read = 0;
	int n_range = 0;
	int n_noop = 0;
	int peak_held = 0;
	bit steady = 1'b0;

	// Apply one request to the expected table and return the response it must produce.
	function automatic rsp_t apply_request(req_t r);
		rsp_t rsp;
		int pos;
		int kept;
		bit found;
		rsp = '0;
		rsp.status = ST_OK;
		case (r.op)
		OP_INSERT: begin
			n_insert++;
			if (held >= TABLE_DEPTH) begin
				rsp.status = ST_FULL;
				n_full++;
			end else begin
				found = 1'b0;
				for (int i = 0; i < held; i++) begin
					if (!found && span_lo[i] == $signed(r.span_start)) begin
						found = 1'b1;
						if (span_hi[i] < $signed(r.span_end))
							span_hi[i] = r.span_end;
					end
				end
				// A new start goes into its sorted place; later entries move up.
				if (!found) begin
					pos = held;
					while (pos > 0 && $signed(r.span_start) < span_lo[pos-1]) begin
						span_lo[pos] = span_lo[pos-1];
						span_hi[pos] = span_hi[pos-1];
						pos--;
					end
					span_lo[pos] = r.span_start;
					span_hi[pos] = r.span_end;
					held++;
				end
			end
		end
		OP_MERGE: begin
			n_merge++;
			// Fold each entry into the last kept one unless there is a gap between them.
			if (held > 0) begin
				kept = 0;
				for (int i = 1; i < held; i++) begin
					if (span_hi[kept] < span_lo[i]) begin
						kept++;
						span_lo[kept] = span_lo[i];
						span_hi[kept] = span_hi[i];
					end else if (span_hi[kept] < span_hi[i]) begin
						span_hi[kept] = span_hi[i];
					end
				end
				held = kept + 1;
			end
		end
		OP_READ: begin
			n_read++;
			if (r.entry_index < held) begin
				rsp.read_start = span_lo[r.entry_index];
				rsp.read_end = span_hi[r.entry_index];
			end else begin
				rsp.status = ST_RANGE;
				n_range++;
			end
		end
		default: begin
			n_noop++;
		end
		endcase
		rsp.entry_count = COUNT_FIELD_W'(held);
		if (held > peak_held)
			peak_held = held;
		return rsp;
	endfunction

	function automatic req_t make_req(logic [1:0] op, logic [31:0] s, logic [31:0] e,
			logic [9:0] idx);
		req_t r;
		r.op = op;
		r.span_start = s;
		r.span_end = e;
		r.entry_index = idx;
		return r;
	endfunction

	// Send one request: optionally idle first, then hold start until the block takes it.
	task automatic send_request(input req_t r);
		int gap;
		if (!steady && $urandom_range(0, 99) < 30) begin
			start <= 1'b0;
			gap = $urandom_range(1, 8);
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		request <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_rsp.push_back(apply_request(r));
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch: expected %h, got %h", $time, name, want, got);
			fail_count++;
		end
	endtask

	// Compare every response with the oldest outstanding expectation.
	always @(posedge clk) begin : rsp_check
		rsp_t want;
		if (done === 1'b1) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t ns: response with no request outstanding: expected none, got %p",
					$time, result);
				fail_count++;
			end else begin
				want = pending_rsp.pop_front();
				rsp_seen++;
				check_field("status", 32'(want.status), 32'(result.status));
				check_field("entry_count", 32'(want.entry_count), 32'(result.entry_count));
				check_field("read_start", want.read_start, result.read_start);
				check_field("read_end", want.read_end, result.read_end);
			end
		end
	end

	// Operations on an empty table, including the unused opcode.
	task automatic test_empty_table();
		send_request(make_req(OP_MERGE, $urandom, $urandom, 10'($urandom)));
		send_request(make_req(OP_READ, $urandom, $urandom, 10'd0));
		send_request(make_req(OP_READ, $urandom, $urandom, 10'h3ff));
		send_request(make_req(OP_UNUSED, $urandom, $urandom, 10'($urandom)));
	endtask

	// Hand-picked intervals: inverted, touching, duplicate starts and coordinate extremes.
	task automatic test_directed_intervals();
		int n;
		send_request(make_req(OP_INSERT, 5 * ONE, 3 * ONE, 10'd0));
		send_request(make_req(OP_INSERT, ONE, 2 * ONE, 10'd0));
		send_request(make_req(OP_INSERT, 2 * ONE, 4 * ONE, 10'd0));
		send_request(make_req(OP_INSERT, ONE, ONE + ONE / 2, 10'd0));
		send_request(make_req(OP_INSERT, ONE, 2 * ONE + ONE / 2, 10'd0));
		send_request(make_req(OP_INSERT, COORD_MAX, COORD_MIN, 10'h3ff));
		send_request(make_req(OP_INSERT, COORD_MIN, 32'hffff_ffff, 10'd0));
		send_request(make_req(OP_INSERT, -3 * ONE, -2 * ONE, 10'd0));
		send_request(make_req(OP_READ, 32'd0, 32'd0, 10'(held)));
		send_request(make_req(OP_MERGE, COORD_MAX, COORD_MIN, 10'h3ff));
		n = held;
		for (int i = 0; i < n; i++)
			send_request(make_req(OP_READ, 32'd0, 32'hffff_ffff, 10'(i)));
		send_request(make_req(OP_READ, COORD_MAX, COORD_MAX, 10'h3ff));
		send_request(make_req(OP_UNUSED, COORD_MIN, COORD_MIN, 10'h2aa));
	endtask

	// Episodes of random requests, each in its own coordinate band; at the end of an
	// episode the band is folded into the head entry so the table stays small.
	task automatic test_random_episodes();
		int band;
		int sent;
		int ep_len;
		int pick;
		logic [31:0] base;
		logic [31:0] s;
		logic [31:0] e;
		logic [9:0] idx;
		logic [1:0] op;
		band = 0;
		sent = 0;
		while (sent < RANDOM_ITEMS && band < BAND_LIMIT) begin
			base = COORD_MIN + band * BAND_W + ONE;
			steady = (band == 3 || band == 4);
			ep_len = $urandom_range(6, 36);
			repeat (ep_len) begin
				pick = $urandom_range(0, 99);
				op = OP_INSERT;
				s = base + ($urandom & 32'h03ff_ffff);
				e = s + ($urandom & 32'h003f_ffff);
				idx = 10'($urandom);
				if (pick < 10) begin
					// Start already held.
					if (held > 0)
						s = span_lo[$urandom_range(0, held - 1)];
					e = s + ($urandom & 32'h003f_ffff);
				end else if (pick < 18) begin
					// Start on a held end, so the two touch.
					if (held > 0)
						s = span_hi[$urandom_range(0, held - 1)];
					e = s + ($urandom & 32'h003f_ffff);
				end else if (pick < 25) begin
					e = s - ($urandom & 32'h000f_ffff) - 1;
				end else if (pick < 55) begin
					op = OP_INSERT;
				end else if (pick < 75) begin
					op = OP_READ;
					if (held > 0 && $urandom_range(0, 4) != 0)
						idx = 10'($urandom_range(0, held - 1));
				end else if (pick < 85) begin
					op = OP_MERGE;
				end else if (pick < 90) begin
					op = OP_UNUSED;
				end else begin
					op = 2'($urandom);
					s = $urandom;
					e = $urandom;
				end
				send_request(make_req(op, s, e, idx));
				sent++;
			end
			send_request(make_req(OP_INSERT, COORD_MIN, base + BAND_W - ONE,
				10'($urandom)));
			send_request(make_req(OP_MERGE, $urandom, $urandom, 10'($urandom)));
			sent += 2;
			band++;
		end
		steady = 1'b0;
	endtask

	// Grow the table well past the episode sizes, then update, read and merge it.
	task automatic test_large_table();
		logic [31:0] s;
		while (held < LARGE_FILL) begin
			s = $urandom;
			send_request(make_req(OP_INSERT, s, s + ($urandom & 32'h0000_ffff),
				10'($urandom)));
		end
		send_request(make_req(OP_INSERT, span_lo[$urandom_range(0, held - 1)], COORD_MAX,
			10'($urandom)));
		send_request(make_req(OP_READ, $urandom, $urandom, 10'(held - 1)));
		send_request(make_req(OP_READ, $urandom, $urandom, 10'(held)));
		send_request(make_req(OP_READ, $urandom, $urandom, 10'h3ff));
		send_request(make_req(OP_READ, $urandom, $urandom, 10'd0));
		send_request(make_req(OP_MERGE, $urandom, $urandom, 10'($urandom)));
		send_request(make_req(OP_READ, $urandom, $urandom, 10'(held - 1)));
		send_request(make_req(OP_READ, $urandom, $urandom, 10'($urandom)));
		send_request(make_req(OP_UNUSED, $urandom, $urandom, 10'($urandom)));
	endtask

	// Let the last responses drain, then watch a little longer for stray strobes.
	task automatic drain_responses();
		start <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_directed_intervals();
		test_random_episodes();
		test_large_table();
		drain_responses();
		$display("Covered %0d requests: %0d inserts (%0d refused as full), %0d merges,",
			n_insert + n_merge + n_read + n_noop, n_insert, n_full, n_merge);
		$display("%0d reads (%0d beyond the count), %0d unused opcodes; largest table %0d.",
			n_read, n_range, n_noop, peak_held);
		$display("%0d responses checked, %0d mismatches.", rsp_seen, fail_count);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#40_000_000;
		$display("Timeout with %0d responses outstanding.", pending_rsp.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule

[sorted_interval_table_merge_top.f]
rtl/sitm_pkg.sv
rtl/sitm_ram.sv
rtl/sitm_cmp.sv
rtl/sorted_interval_table_merge_top.sv
dv/sorted_interval_table_merge_top_tb.sv
